/* sv/sratoa_pkg.sv */
package sratoa_pkg;

    localparam int DIGIT_DEPTH    = 64;
    localparam int DIG_W          = 6;
    localparam int CNT_W          = 7;
    localparam int RADIX_W        = 6;
    localparam int NUM_SLOTS      = 40;
    localparam int NUM_ALPHA_REGS = 5;
    localparam int CFG_IDX_W      = 3;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;

    typedef logic [63:0]                 word_t;
    typedef logic [DIG_W-1:0]            digit_t;
    typedef logic [CNT_W-1:0]            count_t;
    typedef logic [RADIX_W-1:0]          radix_t;
    typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
    typedef logic [NUM_SLOTS-1:0][7:0]   sym_slots_t;

    // register map
    localparam cfg_idx_t CFG_NUM_SYMS = 3'd0;
    localparam cfg_idx_t CFG_ALPHA_0  = 3'd1;
    localparam cfg_idx_t CFG_ALPHA_1  = 3'd2;
    localparam cfg_idx_t CFG_ALPHA_2  = 3'd3;
    localparam cfg_idx_t CFG_ALPHA_3  = 3'd4;
    localparam cfg_idx_t CFG_ALPHA_4  = 3'd5;

    localparam radix_t NUM_SYMS_RESET = 6'd2;
    localparam word_t  ALPHA_0_RESET  = 64'h0000_0000_0000_3130;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_ALPHA   = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OSEL_SIGN,
        OSEL_DIGIT,
        OSEL_ZERO,
        OSEL_ERR_ALPHA,
        OSEL_ERR_RANGE
    } out_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLASS,
        S_DIV,
        S_STORE,
        S_SIGN,
        S_READ,
        S_EMIT,
        S_ERR_ALPHA,
        S_ERR_RANGE,
        S_ZERO
    } state_t;

    typedef struct packed {
        logic     in_ready;
        logic     load;
        logic     chk_step;
        logic     negate;
        logic     div_start;
        logic     div_step;
        logic     store;
        logic     count_dec;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic base_bad;
        logic sym_bad;
        logic chk_last;
        logic is_min;
        logic is_zero;
        logic div_done;
        logic mag_zero;
        logic count_last;
        logic count_one;
        logic neg;
        logic out_free;
    } sts_t;

endpackage

/* sv/sratoa_if.sv */
interface sratoa_num_if import sratoa_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sratoa_sym_if import sratoa_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output symbol, output last, output status, input ready);
    modport sink   (input valid, input symbol, input last, input status, output ready);
endinterface

interface sratoa_cfg_if import sratoa_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    word_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/sratoa_ctrl.sv */
module sratoa_ctrl import sratoa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic num_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (num_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.base_bad || sts.sym_bad)
                begin
                    state_next = S_ERR_ALPHA;
                end
                else if (sts.chk_last)
                begin
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (sts.is_min)
                begin
                    state_next = S_ERR_RANGE;
                end
                else if (sts.is_zero)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                if (!sts.mag_zero && !sts.count_last)
                begin
                    state_next = S_DIV;
                end
                else if (sts.neg)
                begin
                    state_next = S_SIGN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.count_one ? S_IDLE : S_READ;
                end
            end
            S_ERR_ALPHA, S_ERR_RANGE, S_ZERO:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.out_sel = OSEL_DIGIT;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = num_valid;
            end
            S_CHECK:
            begin
                cmd.chk_step = 1'b1;
            end
            S_CLASS:
            begin
                cmd.negate    = 1'b1;
                cmd.div_start = 1'b1;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            S_STORE:
            begin
                cmd.store     = 1'b1;
                cmd.div_start = 1'b1;
            end
            S_SIGN:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OSEL_SIGN;
            end
            S_EMIT:
            begin
                cmd.out_load  = sts.out_free;
                cmd.count_dec = sts.out_free;
                cmd.out_sel   = OSEL_DIGIT;
            end
            S_ERR_ALPHA:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OSEL_ERR_ALPHA;
            end
            S_ERR_RANGE:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OSEL_ERR_RANGE;
            end
            S_ZERO:
            begin
                cmd.out_load = sts.out_free;
                cmd.out_sel  = OSEL_ZERO;
            end
            default:
            begin
                cmd.out_sel = OSEL_DIGIT;
            end
        endcase
    end

    // the output register is never overwritten while it still holds a beat
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output beat overwritten");

    // a finished division always lands in the digit store next
    a_div_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && sts.div_done) |=> cmd.store)
        else $error("digit not stored after division");

endmodule

/* sv/sratoa_dp.sv */
module sratoa_dp import sratoa_pkg::*;
#(
    parameter int MAX_SYMBOLS = 40
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  word_t      num_value,
    output logic       text_valid,
    input  logic       text_ready,
    output logic [7:0] text_symbol,
    output logic       text_last,
    output logic [1:0] text_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_idx_t   cfg_index,
    input  word_t      cfg_data
);

    radix_t     num_syms_reg;
    word_t      alpha_reg [NUM_ALPHA_REGS];
    sym_slots_t slots;

    word_t      mag_reg;
    logic       neg_reg;
    digit_t     rem_reg;
    digit_t     rem_next;
    logic [6:0] rem_sh;
    logic       quot_bit;
    digit_t     bit_cnt_reg;
    count_t     count_reg;
    digit_t     chk_idx_reg;
    digit_t     rd_addr;
    digit_t     rd_data_reg;
    digit_t     digit_mem [DIGIT_DEPTH];

    logic       out_valid_reg;
    logic [7:0] out_symbol_reg;
    logic       out_last_reg;
    logic [1:0] out_status_reg;

    logic [7:0] chk_sym;
    logic       dup_found;
    digit_t     emit_idx;
    logic [7:0] emit_sym;

    function automatic logic [7:0] sym_at(input sym_slots_t s, input digit_t idx);
        logic [7:0] r;
        r = 8'd0;
        if (int'(idx) < MAX_SYMBOLS)
        begin
            r = s[idx];
        end
        return r;
    endfunction

    // ---- configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_syms_reg <= NUM_SYMS_RESET;
            alpha_reg[0] <= ALPHA_0_RESET;
            for (int k = 1; k < NUM_ALPHA_REGS; k++)
            begin
                alpha_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NUM_SYMS: num_syms_reg <= cfg_data[RADIX_W-1:0];
                CFG_ALPHA_0:  alpha_reg[0] <= cfg_data;
                CFG_ALPHA_1:  alpha_reg[1] <= cfg_data;
                CFG_ALPHA_2:  alpha_reg[2] <= cfg_data;
                CFG_ALPHA_3:  alpha_reg[3] <= cfg_data;
                CFG_ALPHA_4:  alpha_reg[4] <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign slots = {alpha_reg[4], alpha_reg[3], alpha_reg[2], alpha_reg[1], alpha_reg[0]};

    // ---- alphabet check, one symbol per cycle against all later ones
    assign chk_sym = sym_at(slots, chk_idx_reg);

    always_comb
    begin
        dup_found = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if (DIG_W'(j) > chk_idx_reg && DIG_W'(j) < num_syms_reg && slots[j] == chk_sym)
            begin
                dup_found = 1'b1;
            end
        end
    end

    // ---- bit-serial restoring divider
    assign rem_sh   = {rem_reg, mag_reg[63]};
    assign quot_bit = rem_sh >= {1'b0, num_syms_reg};
    assign rem_next = quot_bit ? DIG_W'(rem_sh - {1'b0, num_syms_reg}) : rem_sh[DIG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= num_value;
            neg_reg <= num_value[63];
        end
        else if (cmd.negate)
        begin
            if (neg_reg)
            begin
                mag_reg <= ~mag_reg + 64'd1;
            end
        end
        else if (cmd.div_step)
        begin
            mag_reg <= {mag_reg[62:0], quot_bit};
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            chk_idx_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                bit_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end

            if (cmd.load)
            begin
                chk_idx_reg <= '0;
            end
            else if (cmd.chk_step)
            begin
                chk_idx_reg <= chk_idx_reg + 1'b1;
            end

            if (cmd.load)
            begin
                count_reg <= '0;
            end
            else if (cmd.store)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.count_dec)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // ---- digit store, least significant digit at address 0
    assign rd_addr = count_reg[DIG_W-1:0] - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            digit_mem[count_reg[DIG_W-1:0]] <= rem_reg;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    // ---- output register
    assign emit_idx = (cmd.out_sel == OSEL_ZERO) ? '0 : rd_data_reg;
    assign emit_sym = sym_at(slots, emit_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (text_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OSEL_SIGN:
                begin
                    out_symbol_reg <= MINUS_CHAR;
                    out_last_reg   <= 1'b0;
                    out_status_reg <= ST_OK;
                end
                OSEL_DIGIT:
                begin
                    out_symbol_reg <= emit_sym;
                    out_last_reg   <= sts.count_one;
                    out_status_reg <= ST_OK;
                end
                OSEL_ZERO:
                begin
                    out_symbol_reg <= emit_sym;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= ST_OK;
                end
                OSEL_ERR_ALPHA:
                begin
                    out_symbol_reg <= 8'd0;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= ST_BAD_ALPHA;
                end
                OSEL_ERR_RANGE:
                begin
                    out_symbol_reg <= 8'd0;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= ST_OUT_OF_RANGE;
                end
                default:
                begin
                    out_symbol_reg <= 8'd0;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= ST_OK;
                end
            endcase
        end
    end

    assign text_valid  = out_valid_reg;
    assign text_symbol = out_symbol_reg;
    assign text_last   = out_last_reg;
    assign text_status = out_status_reg;

    // ---- status to controller
    always_comb
    begin
        sts            = '0;
        sts.base_bad   = (num_syms_reg < 6'd2) || (num_syms_reg > RADIX_W'(MAX_SYMBOLS));
        sts.sym_bad    = (chk_sym == 8'd0) || dup_found;
        sts.chk_last   = chk_idx_reg == (num_syms_reg - 1'b1);
        sts.is_min     = mag_reg == {1'b1, 63'd0};
        sts.is_zero    = mag_reg == '0;
        sts.div_done   = bit_cnt_reg == '1;
        sts.mag_zero   = mag_reg == '0;
        sts.count_last = count_reg == CNT_W'(DIGIT_DEPTH - 1);
        sts.count_one  = count_reg == CNT_W'(1);
        sts.neg        = neg_reg;
        sts.out_free   = !out_valid_reg || text_ready;
    end

    a_store_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !count_reg[CNT_W-1])
        else $error("digit store overflow");

    a_digit_avail: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_sel == OSEL_DIGIT) |-> count_reg != '0)
        else $error("digit emitted with empty store");

endmodule

/* sv/signed_radix_to_ascii.sv */
// Channel   Modport  Beat payload                        Notes
// number    sink     value[63:0] signed                  one beat per conversion
// text      source   symbol[7:0], last, status[1:0]      MSD first, last on final beat
// cfg       sink     index[2:0], data[63:0]              0 num_syms, 1..5 alphabet_0..4
//
// Steps per item: accept, alphabet check of up to num_syms symbols, a classify step, then
// per digit a 64-step bit-serial divider pass plus a store, then a read and an emit for
// each emitted digit, after a sign beat if negative. Errors and zero give a single beat
// after the check.
// Reset: rst_n async, config back to num_syms 2 / alphabet "01". No clearing pass.
// Stalls: text.ready low holds the output register; the controller waits on it.
module signed_radix_to_ascii import sratoa_pkg::*;
#(
    parameter int MAX_SYMBOLS = 40
)
(
    input  logic       clk,
    input  logic       rst_n,
    sratoa_num_if.sink   number,
    sratoa_sym_if.source text,
    sratoa_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;

    // number is taken only by the controller's idle state
    assign number.ready = cmd.in_ready;

    sratoa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (number.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: config regs, alphabet check, divider, digit store, output reg
    sratoa_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .num_value   (number.value),
        .text_valid  (text.valid),
        .text_ready  (text.ready),
        .text_symbol (text.symbol),
        .text_last   (text.last),
        .text_status (text.status),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

// Stimulus and checking for the signed radix-to-text converter.
// Numbers go in on the number channel. The converted text comes back one beat per symbol.
// A small tracker class predicts every text beat from its own copy of the radix and the
// alphabet. The radix and the alphabet are the registers written over the cfg channel.
module testbench import sratoa_pkg::*; ();

    localparam int     RANDOM_PHASES    = 7;
    localparam int     ITEMS_PER_PHASE  = 17;
    localparam int     LONG_HOLD_CYCLES = 3000;
    // The converter goes idle after its final beat. This settle window is
    // mostly there to catch stray beats.
    localparam int     DRAIN_CYCLES     = 300;
    // The worst correct run is about 140 numbers. Each one is radix 2 with 64 beats,
    // with a full division per digit plus output stalls. The limit leaves a wide
    // margin over that.
    localparam longint CYCLE_LIMIT      = 4_000_000;

    localparam word_t MOST_NEG = 64'h8000_0000_0000_0000;
    localparam word_t MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam word_t EDGE_VALUES [5] = '{MOST_NEG, MOST_POS, MOST_NEG + 64'd1, '1, 64'd1};
    localparam cfg_idx_t ALPHA_INDEX [NUM_ALPHA_REGS] =
        '{CFG_ALPHA_0, CFG_ALPHA_1, CFG_ALPHA_2, CFG_ALPHA_3, CFG_ALPHA_4};

    // All five alphabet registers as one vector. Symbol i sits in byte i.
    typedef logic [NUM_ALPHA_REGS-1:0][63:0] alpha_regs_t;

    typedef enum {FLAW_NONE, FLAW_ZERO, FLAW_DUP} alpha_flaw_t;
    typedef enum {SINK_OPEN, SINK_COIN, SINK_PATTERN} sink_mode_t;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
        status_t    status;
    } text_beat_t;

    // Keeps its own copy of the registers, predicts the text for each number taken,
    // and checks the returned beats in order.
    class text_tracker_t;
        logic [5:0]  num_syms;
        alpha_regs_t alpha;
        text_beat_t  pending_text[$];
        int          fails;
        int          beats_checked;
        int          numbers_taken;

        function new();
            num_syms      = NUM_SYMS_RESET;
            alpha         = '0;
            alpha[0]      = ALPHA_0_RESET;
            fails         = 0;
            beats_checked = 0;
            numbers_taken = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, word_t data);
            case (idx)
                CFG_NUM_SYMS: num_syms = data[5:0];
                CFG_ALPHA_0:  alpha[0] = data;
                CFG_ALPHA_1:  alpha[1] = data;
                CFG_ALPHA_2:  alpha[2] = data;
                CFG_ALPHA_3:  alpha[3] = data;
                CFG_ALPHA_4:  alpha[4] = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] symbol_of(int unsigned slot);
            return alpha[slot / 8][(slot % 8) * 8 +: 8];
        endfunction

        function bit alphabet_ok();
            int unsigned n;
            int unsigned i;
            int unsigned j;
            n = num_syms;
            if (n < 2 || n > NUM_SLOTS)
                return 1'b0;
            for (i = 0; i < n; i++)
            begin
                if (symbol_of(i) == 8'h00)
                    return 1'b0;
                for (j = i + 1; j < n; j++)
                    if (symbol_of(j) == symbol_of(i))
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void push(logic [7:0] symbol, logic last, status_t status);
            text_beat_t beat;
            beat.symbol = symbol;
            beat.last   = last;
            beat.status = status;
            pending_text.push_back(beat);
        endfunction

        function void note_number(word_t value);
            logic [5:0]  digits [DIGIT_DEPTH];
            logic [63:0] mag;
            logic [63:0] radix;
            int          count;
            int          k;
            numbers_taken++;
            // The alphabet check wins over the range check.
            if (!alphabet_ok())
            begin
                push(8'h00, 1'b1, ST_BAD_ALPHA);
                return;
            end
            if (value == MOST_NEG)
            begin
                push(8'h00, 1'b1, ST_OUT_OF_RANGE);
                return;
            end
            if (value == '0)
            begin
                push(symbol_of(0), 1'b1, ST_OK);
                return;
            end
            mag   = value[63] ? (~value + 64'd1) : value;
            radix = 64'(num_syms);
            count = 0;
            while (mag != '0 && count < DIGIT_DEPTH)
            begin
                digits[count] = 6'(mag % radix);
                mag           = mag / radix;
                count++;
            end
            if (value[63])
                push(MINUS_CHAR, 1'b0, ST_OK);
            for (k = count; k > 0; k--)
                push(symbol_of(digits[k-1]), k == 1, ST_OK);
        endfunction

        function void check_beat(logic [7:0] symbol, logic last, logic [1:0] status);
            text_beat_t want;
            beats_checked++;
            if (pending_text.size() == 0)
            begin
                fails++;
                $error("unexpected text beat: symbol %02h last %0b status %0d",
                       symbol, last, status);
                return;
            end
            want = pending_text.pop_front();
            if (symbol !== want.symbol)
            begin
                fails++;
                $error("symbol: expected %02h, got %02h", want.symbol, symbol);
            end
            if (last !== want.last)
            begin
                fails++;
                $error("last: expected %0b, got %0b", want.last, last);
            end
            if (status !== want.status)
            begin
                fails++;
                $error("status: expected %0d, got %0d", want.status, status);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    sratoa_num_if number_bus ();
    sratoa_sym_if text_bus ();
    sratoa_cfg_if cfg_bus ();

    signed_radix_to_ascii i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_bus),
        .text   (text_bus),
        .cfg    (cfg_bus)
    );

    text_tracker_t   tracker         = new();
    longint unsigned cycle_count     = 0;
    int              burst_left      = 0;
    int              settings_loaded = 0;
    bit              long_hold_armed = 1'b0;

    always #1 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Random used symbols, all distinct and nonzero. Bytes past n are junk, so zeros and
    // repeats show up there. They must be ignored. A flaw breaks the used part on purpose.
    function automatic alpha_regs_t make_alphabet(input int n, input alpha_flaw_t flaw);
        logic [7:0]  sym [NUM_SLOTS];
        bit          used [256];
        alpha_regs_t regs;
        int          i;
        int          j;
        for (i = 0; i < 256; i++)
            used[i] = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            if (i < n)
            begin
                do
                    sym[i] = 8'($urandom_range(1, 255));
                while (used[sym[i]]);
                used[sym[i]] = 1'b1;
            end
            else
                sym[i] = 8'($urandom_range(0, 255));
        end
        if (flaw == FLAW_ZERO)
            sym[$urandom_range(0, n - 1)] = 8'h00;
        else if (flaw == FLAW_DUP)
        begin
            j      = $urandom_range(1, n - 1);
            i      = $urandom_range(0, j - 1);
            sym[j] = sym[i];
        end
        for (i = 0; i < NUM_SLOTS; i++)
            regs[i / 8][(i % 8) * 8 +: 8] = sym[i];
        return regs;
    endfunction

    // The value mix leans toward full-width randoms. It also takes in small signed
    // numbers, powers of two with their neighbors, zero, the range edges and shifted
    // randoms.
    function automatic word_t random_value();
        word_t v;
        int    kind;
        kind = $urandom_range(0, 9);
        v    = {$urandom, $urandom};
        if (kind < 4)
            ;
        else if (kind == 4)
            v = word_t'(longint'($urandom_range(0, 2000)) - 1000);
        else if (kind == 5)
        begin
            v = (64'd1 << $urandom_range(0, 62)) + word_t'(longint'($urandom_range(0, 2)) - 1);
            if ($urandom_range(0, 1))
                v = ~v + 64'd1;
        end
        else if (kind == 6)
            v = '0;
        else if (kind == 7)
            v = EDGE_VALUES[$urandom_range(0, 4)];
        else
        begin
            v = v >> $urandom_range(1, 62);
            if ($urandom_range(0, 1))
                v = ~v + 64'd1;
        end
        return v;
    endfunction

    // The sender works in bursts. A new burst sometimes starts right away and sometimes
    // after a random gap. The prediction is made at the accepting edge.
    task automatic offer_number(input word_t value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                number_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        number_bus.valid <= 1'b1;
        number_bus.value <= value;
        do
            @(posedge clk);
        while (number_bus.ready !== 1'b1);
        tracker.note_number(value);
    endtask

    // Stop offering and wait until every predicted beat is back. After that the
    // converter is idle and safe to reprogram.
    task automatic drain_text();
        number_bus.valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_text.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg valid high across back-to-back writes. load_settings lowers it.
    task automatic write_reg(input cfg_idx_t idx, input word_t data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_settings(input word_t base_word, input alpha_regs_t alpha);
        int r;
        write_reg(CFG_NUM_SYMS, base_word);
        for (r = 0; r < NUM_ALPHA_REGS; r++)
            write_reg(ALPHA_INDEX[r], alpha[r]);
        cfg_bus.valid <= 1'b0;
        settings_loaded++;
    endtask

    // One number under a broken or odd setting, then back to idle.
    task automatic probe_setting(input word_t base_word, input alpha_regs_t alpha,
                                 input word_t value);
        load_settings(base_word, alpha);
        offer_number(value);
        drain_text();
    endtask

    // Text sink: checks each beat and then picks ready for the next edge. It mostly
    // runs random windows: always ready, coin-flip ready, or a rotating stall
    // pattern. Once armed, it holds ready low for a long stretch. The converter then
    // backs up and the number channel stalls.
    initial
    begin : text_sink
        int unsigned hold_left;
        int unsigned window_left;
        bit          hold_done;
        sink_mode_t  mode;
        logic [7:0]  pattern;
        hold_left   = 0;
        window_left = 0;
        hold_done   = 1'b0;
        mode        = SINK_OPEN;
        pattern     = 8'hFF;
        text_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (text_bus.valid === 1'b1 && text_bus.ready === 1'b1)
                tracker.check_beat(text_bus.symbol, text_bus.last, text_bus.status);
            if (long_hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                text_bus.ready <= 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    window_left = $urandom_range(16, 160);
                    mode        = sink_mode_t'($urandom_range(0, 2));
                    pattern     = 8'($urandom_range(1, 255));
                end
                window_left--;
                case (mode)
                    SINK_OPEN: text_bus.ready <= 1'b1;
                    SINK_COIN: text_bus.ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        text_bus.ready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    initial
    begin : stimulus
        word_t       base_word;
        int          n;
        int          pick;
        int          p;
        alpha_flaw_t flaw;

        rst_n            = 1'b0;
        number_bus.valid = 1'b0;
        number_bus.value = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = CFG_NUM_SYMS;
        cfg_bus.data     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting is binary "01". The most negative value plus one gives the
        // longest text: a sign and 63 digits.
        offer_number('0);
        offer_number(64'd1);
        offer_number('1);
        offer_number(MOST_POS);
        offer_number(MOST_NEG);
        offer_number(MOST_NEG + 64'd1);
        offer_number(64'd2);
        drain_text();

        // Decimal. The symbol count word has junk in its upper bits, and the unused
        // bytes of alphabet_1..4 carry zeros and repeats.
        load_settings(64'hFFFF_FFFF_FFFF_FFCA,
                      {64'h3131_0000_3131_0000, 64'h0,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'h00FF_3900_3000_3938,
                       64'h3736_3534_3332_3130});
        offer_number('0);
        offer_number(word_t'(-64'sd12345));
        offer_number(MOST_POS);
        offer_number(64'd9);
        offer_number(64'd10);
        drain_text();

        // Widest radix, with all 40 slots in use.
        load_settings(64'd40, make_alphabet(NUM_SLOTS, FLAW_NONE));
        offer_number('1);
        offer_number(MOST_POS);
        offer_number(64'd39);
        offer_number(64'd40);
        offer_number(MOST_NEG + 64'd1);
        drain_text();

        // Bad alphabets. The alphabet error must win even over the most negative value.
        probe_setting('0, make_alphabet(2, FLAW_NONE), MOST_NEG);
        probe_setting(64'd1, make_alphabet(2, FLAW_NONE), 64'd5);
        probe_setting('1, make_alphabet(NUM_SLOTS, FLAW_NONE), word_t'(-64'sd7));
        probe_setting(64'd41, make_alphabet(NUM_SLOTS, FLAW_NONE), '0);
        probe_setting(64'd16, make_alphabet(16, FLAW_ZERO), 64'd100);
        probe_setting(64'd40, make_alphabet(NUM_SLOTS, FLAW_DUP), word_t'(-64'sd100));

        // Random phases. Each one gets a fresh setting: mostly a valid radix from 3 to
        // 39, now and then radix 2, radix 40, a flawed alphabet or an oversized
        // symbol count.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                n = 2;
            else if (pick == 1)
                n = NUM_SLOTS;
            else
                n = $urandom_range(3, NUM_SLOTS - 1);
            flaw = (pick == 2) ? alpha_flaw_t'($urandom_range(1, 2)) : FLAW_NONE;
            base_word      = {$urandom, $urandom};
            base_word[5:0] = 6'(n);
            if (pick == 3)
                base_word[5:0] = 6'($urandom_range(NUM_SLOTS + 1, 63));
            load_settings(base_word, make_alphabet(n, flaw));
            if (p == 1)
                long_hold_armed = 1'b1;
            repeat (ITEMS_PER_PHASE) offer_number(random_value());
            drain_text();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("summary: %0d numbers converted under %0d register settings, %0d text beats",
                 tracker.numbers_taken, settings_loaded, tracker.beats_checked);
        $display("summary: radix 2 to 40, bad alphabets, zero, range edges, one long sink hold");
        if (tracker.fails == 0 && tracker.pending_text.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
